FILE: rtl/plsf_pkg.sv
// ----------------------------------------------------------------------------
// plsf_pkg: shared types and constants for the lattice site flip unit
// request codes, payload structs, controller/datapath command and status
// ----------------------------------------------------------------------------
package plsf_pkg;

  localparam int EDGE_X_DEF    = 16;
  localparam int EDGE_Y_DEF    = 16;
  localparam int EDGE_Z_DEF    = 16;
  localparam int SPIN_BITS_DEF = 16;

  localparam logic [1:0] REQ_WRITE   = 2'd0;
  localparam logic [1:0] REQ_READ    = 2'd1;
  localparam logic [1:0] REQ_PROPOSE = 2'd2;
  localparam logic [1:0] REQ_NONE    = 2'd3;  // unused code, answered with an all-zero response

  typedef struct packed {
    logic [1:0]  req_type;
    logic [4:0]  site_x;
    logic [4:0]  site_y;
    logic [4:0]  site_z;
    logic [15:0] spin_value;
  } req_t;

  typedef struct packed {
    logic [15:0] spin_out;
    logic        accepted;
    logic [4:0]  old_matches;
    logic [4:0]  new_matches;
    logic        bad_site;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture request
    logic clr_addr;   // clear store address counter
    logic clr_step;   // clear neighbour walk
    logic step;       // advance neighbour walk
    logic rd_here;    // read the target site
    logic rd_nb;      // read the current neighbour
    logic cap_here;   // capture read data as old spin
    logic cnt_nb;     // count read data as neighbour
    logic wr_req;     // write request value to target site
    logic wr_clear;   // clearing pass write
    logic fin;        // build result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_lattice;
    logic interior;
    logic last_nb;
    logic clr_done;
    logic flip_ok;
    logic [1:0] kind;
  } sts_t;

endpackage

FILE: rtl/plsf_datapath.sv
// ----------------------------------------------------------------------------
// plsf_datapath: spin store, neighbour walk and match counters
// single port memory, one read or write per cycle
// ----------------------------------------------------------------------------
module plsf_datapath #(
  parameter int EDGE_X    = plsf_pkg::EDGE_X_DEF,
  parameter int EDGE_Y    = plsf_pkg::EDGE_Y_DEF,
  parameter int EDGE_Z    = plsf_pkg::EDGE_Z_DEF,
  parameter int SPIN_BITS = plsf_pkg::SPIN_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  plsf_pkg::req_t  req,
  input  plsf_pkg::cmd_t  cmd,
  output plsf_pkg::sts_t  sts,
  output plsf_pkg::rsp_t  rsp
);

  localparam int SPAN_X = EDGE_X + 2;
  localparam int SPAN_Y = EDGE_Y + 2;
  localparam int SPAN_Z = EDGE_Z + 2;
  localparam int DEPTH  = SPAN_X * SPAN_Y * SPAN_Z;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(SPAN_X > SPAN_Y ? (SPAN_X > SPAN_Z ? SPAN_X : SPAN_Z)
                                                 : (SPAN_Y > SPAN_Z ? SPAN_Y : SPAN_Z)) + 1;

  logic [SPIN_BITS-1:0] mem [DEPTH];
  logic [SPIN_BITS-1:0] rdata;

  logic [1:0]  kind;
  logic [CW-1:0] cx, cy, cz;
  logic [SPIN_BITS-1:0] val, old;
  logic [1:0]  dx, dy, dz;        // offsets 0..2, meaning -1..+1
  logic [4:0]  nold, nnew;
  logic [AW-1:0] clr_addr;
  plsf_pkg::rsp_t rsp_r, rsp_next;

  logic [CW-1:0] nx, ny, nz;
  logic [AW+CW-1:0] here_a, nb_a, wa, ra;

  always_comb begin
    nx = cx + CW'(dx) - CW'(1);
    ny = cy + CW'(dy) - CW'(1);
    nz = cz + CW'(dz) - CW'(1);
    here_a = ((AW+CW)'(cx) * (AW+CW)'(SPAN_Y) + (AW+CW)'(cy)) * (AW+CW)'(SPAN_Z)
             + (AW+CW)'(cz);
    nb_a   = ((AW+CW)'(nx) * (AW+CW)'(SPAN_Y) + (AW+CW)'(ny)) * (AW+CW)'(SPAN_Z)
             + (AW+CW)'(nz);
    ra = cmd.rd_nb ? nb_a : here_a;
    wa = cmd.wr_clear ? (AW+CW)'(clr_addr) : here_a;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_clear || cmd.wr_req)
      mem[wa[AW-1:0]] <= cmd.wr_clear ? '0 : val;
    if (cmd.rd_here || cmd.rd_nb)
      rdata <= mem[ra[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      dx <= '0; dy <= '0; dz <= '0;
      nold <= '0; nnew <= '0;
    end else begin
      if (cmd.clr_addr) clr_addr <= '0;
      else if (cmd.wr_clear) clr_addr <= clr_addr + AW'(1);
      if (cmd.clr_step) begin
        dx <= '0; dy <= '0; dz <= '0;
        nold <= '0; nnew <= '0;
      end else begin
        if (cmd.step) begin
          // skip the centre offset
          if (dz == 2'd2 || (dx == 2'd1 && dy == 2'd1 && dz == 2'd0)) begin
            dz <= (dx == 2'd1 && dy == 2'd1 && dz == 2'd0) ? 2'd2 : 2'd0;
            if (dz == 2'd2) begin
              if (dy == 2'd2) begin dy <= 2'd0; dx <= dx + 2'd1; end
              else dy <= dy + 2'd1;
            end
          end else dz <= dz + 2'd1;
        end
        if (cmd.cnt_nb) begin
          if (rdata == old) nold <= nold + 5'd1;
          if (rdata == val) nnew <= nnew + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= req.req_type;
      cx <= CW'(req.site_x); cy <= CW'(req.site_y); cz <= CW'(req.site_z);
      val <= SPIN_BITS'(req.spin_value);
    end
    if (cmd.cap_here) old <= rdata;
  end

  always_comb begin
    sts.kind       = kind;
    sts.in_lattice = cx < CW'(SPAN_X) && cy < CW'(SPAN_Y) && cz < CW'(SPAN_Z);
    sts.interior   = cx >= CW'(1) && cx <= CW'(EDGE_X) && cy >= CW'(1) && cy <= CW'(EDGE_Y)
                     && cz >= CW'(1) && cz <= CW'(EDGE_Z);
    sts.last_nb    = dx == 2'd2 && dy == 2'd2 && dz == 2'd2;
    sts.clr_done   = clr_addr == AW'(DEPTH - 1);
    sts.flip_ok    = nold <= nnew;
  end

  // result assembly
  always_comb begin
    rsp_next = '0;
    if (kind != plsf_pkg::REQ_NONE && !sts.in_lattice) rsp_next.bad_site = 1'b1;
    else if (kind == plsf_pkg::REQ_WRITE) rsp_next.spin_out = 16'(val);
    else if (kind == plsf_pkg::REQ_READ) rsp_next.spin_out = 16'(rdata);
    else if (kind == plsf_pkg::REQ_PROPOSE) begin
      if (!sts.interior) begin
        rsp_next.bad_site = 1'b1;
        rsp_next.spin_out = 16'(rdata);
      end else begin
        rsp_next.old_matches = nold;
        rsp_next.new_matches = nnew;
        rsp_next.accepted    = sts.flip_ok;
        rsp_next.spin_out    = sts.flip_ok ? 16'(val) : 16'(old);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) rsp_r <= rsp_next;
  end

  assign rsp = rsp_r;

endmodule

FILE: rtl/plsf_ctrl.sv
// ----------------------------------------------------------------------------
// plsf_ctrl: sequencer for clearing pass, read, write and flip walk
// ----------------------------------------------------------------------------
module plsf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  plsf_pkg::sts_t sts,
  output plsf_pkg::cmd_t cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_HERE  = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_LAST  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state, state_next;
  logic       outv, outv_next;
  logic       walk_rd;  // a neighbour read is in flight

  assign out_valid = outv;
  assign in_stall  = !(state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    outv_next = outv && out_stall;
    case (state)
      S_CLEAR: begin
        cmd.wr_clear = 1'b1;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load = 1'b1;
          cmd.clr_step = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.kind != plsf_pkg::REQ_NONE && !sts.in_lattice) state_next = S_FIN;
        else if (sts.kind == plsf_pkg::REQ_WRITE) begin
          cmd.wr_req = 1'b1; state_next = S_FIN;
        end else if (sts.kind == plsf_pkg::REQ_READ || sts.kind == plsf_pkg::REQ_PROPOSE) begin
          cmd.rd_here = 1'b1; state_next = S_HERE;
        end else state_next = S_FIN;
      end
      S_HERE: begin
        cmd.cap_here = 1'b1;
        if (sts.kind == plsf_pkg::REQ_PROPOSE && sts.interior) begin
          cmd.rd_nb = 1'b1; cmd.step = 1'b1; state_next = S_WALK;
        end else state_next = S_FIN;
      end
      S_WALK: begin
        cmd.cnt_nb = walk_rd;
        if (sts.last_nb) begin
          // final offset 2,2,2 reached by the previous step; read it without stepping
          cmd.rd_nb = 1'b1; state_next = S_LAST;
        end else begin
          cmd.rd_nb = 1'b1; cmd.step = 1'b1;
        end
      end
      S_LAST: begin
        cmd.cnt_nb = 1'b1; state_next = S_FIN;
      end
      S_FIN: begin
        if (!(outv && out_stall)) begin
          cmd.fin = 1'b1;
          outv_next = 1'b1;
          state_next = S_IDLE;
          // write-back when the flip wins
          if (sts.kind == plsf_pkg::REQ_PROPOSE && sts.in_lattice && sts.interior
              && sts.flip_ok)
            cmd.wr_req = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      outv <= 1'b0;
      walk_rd <= 1'b0;
    end else begin
      state <= state_next;
      outv <= outv_next;
      walk_rd <= (state == S_WALK) || (state == S_HERE && cmd.rd_nb);
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> state == S_IDLE) else $error("accept while busy");
  a_fin_free: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> !(outv && out_stall)) else $error("result overwritten");
  a_fin_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |=> outv) else $error("result lost");
`endif

endmodule

FILE: rtl/potts_lattice_site_flip_unit.sv
// ----------------------------------------------------------------------------
// potts_lattice_site_flip_unit: 3d potts lattice with 26-neighbour flip test
// usage: one request transaction in, one response transaction out.
//   write: decode, store write, result. read: decode, site read, result.
//   proposal at an interior site: the store reads the site and its 26
//   neighbours in turn, then writes back once if the flip is accepted.
//   one request is in work at a time; in_stall is high while busy,
//   so a new request is taken only once the last result is registered.
// reset: a clearing pass zeroes the whole store of (EDGE_X+2)*(EDGE_Y+2)*(EDGE_Z+2)
//   entries (5832 at default), one entry per cycle, input held off.
// output: the response is held in a register; while out_stall is high it
//   stays, and a new request is taken but its result waits for the slot.
// ----------------------------------------------------------------------------
module potts_lattice_site_flip_unit #(
  parameter int EDGE_X    = plsf_pkg::EDGE_X_DEF,
  parameter int EDGE_Y    = plsf_pkg::EDGE_Y_DEF,
  parameter int EDGE_Z    = plsf_pkg::EDGE_Z_DEF,
  parameter int SPIN_BITS = plsf_pkg::SPIN_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  plsf_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output plsf_pkg::rsp_t out_data
);

  plsf_pkg::cmd_t cmd;   // controller commands
  plsf_pkg::sts_t sts;   // datapath status

  plsf_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  plsf_datapath #(
    .EDGE_X(EDGE_X), .EDGE_Y(EDGE_Y), .EDGE_Z(EDGE_Z), .SPIN_BITS(SPIN_BITS)
  ) u_dp (
    .clk, .rst, .req(in_data), .cmd, .sts, .rsp(out_data)
  );

endmodule
